// ===== hw/rtl/ccwc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccwc_pkg
// Shared widths, reset values and the saturating table add for the coin
// change way counter.
// ----------------------------------------------------------------------------
package ccwc_pkg;

    localparam int AMT_W      = 12;
    localparam int FIRST_W    = 3;
    localparam int COIN_W     = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_REGS   = 6;
    localparam int COIN_IDX_W = 4;
    localparam int ENTRY_W    = 64;
    localparam int COUNT_W    = 63;
    localparam int CMP_W      = 17;

    localparam int DEF_MAX_AMOUNT = 4096;
    localparam int DEF_NUM_COINS  = 6;

    typedef logic [COIN_W-1:0]  t_coin;
    typedef logic [ENTRY_W-1:0] t_entry;

    localparam t_coin COIN_RESET [CFG_REGS] = '{
        COIN_W'(240), COIN_W'(24), COIN_W'(12), COIN_W'(6), COIN_W'(3), COIN_W'(1)
    };

    // Bit 63 marks a saturated count; a saturated result is all ones.
    function automatic t_entry sat_add(input t_entry a, input t_entry b);
        t_entry sum;
        logic   mark;
        sum  = {1'b0, a[COUNT_W-1:0]} + {1'b0, b[COUNT_W-1:0]};
        mark = a[ENTRY_W-1] | b[ENTRY_W-1] | sum[ENTRY_W-1];
        return mark ? '1 : sum;
    endfunction

endpackage

// ===== hw/rtl/ccwc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccwc_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module ccwc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== hw/rtl/coin_change_way_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coin_change_way_counter
// Counts unordered coin combinations that sum to an amount, with a bottom-up
// table over 0..amount and one saturating table update per cycle.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+--------------------------
//   in      | in        | i_in_valid / o_in_stall    | i_amount, i_first_coin
//   out     | out       | o_out_valid / i_out_stall  | o_ways, o_overflow
//   cfg     | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Each query clears entries 0..amount, then makes one update pass over c..amount
// for each usable coin c, scanning coin indices from i_first_coin upward.
// The rate is set by the table RAM: one read pair and one write per update.
// The table holds no reset state; every in-range query writes 0..amount first.
// o_in_stall is high from acceptance until the result enters the out register.
// A stalled result holds; the next query is taken while it waits.
// ----------------------------------------------------------------------------
module coin_change_way_counter #(
    parameter int MAX_AMOUNT = ccwc_pkg::DEF_MAX_AMOUNT,
    parameter int NUM_COINS  = ccwc_pkg::DEF_NUM_COINS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [ccwc_pkg::AMT_W-1:0]     i_amount,
    input  logic [ccwc_pkg::FIRST_W-1:0]   i_first_coin,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [ccwc_pkg::COUNT_W-1:0]   o_ways,
    output logic                           o_overflow,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ccwc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ccwc_pkg::COIN_W-1:0]    i_cfg_data
);

    import ccwc_pkg::*;

    localparam int AW = $clog2(MAX_AMOUNT);

    typedef enum logic [2:0] {
        S_IDLE, S_CLEAR, S_SEL, S_PASS, S_RD, S_WAIT, S_DONE
    } t_state;

    t_state                r_state;
    t_coin                 r_coin_reg [CFG_REGS];
    logic [AW-1:0]         r_amount;
    logic [AW-1:0]         r_addr;
    logic [AW-1:0]         r_c;
    logic [COIN_IDX_W-1:0] r_coin;
    t_entry                r_res;

    logic                  r_p1;
    logic [AW-1:0]         r_p1_addr;
    logic [AW-1:0]         r_p1_baddr;
    logic                  r_fw_vld;
    logic [AW-1:0]         r_fw_addr;
    t_entry                r_fw_data;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    t_entry                ram_wdata;
    logic [AW-1:0]         ram_raddr_a;
    logic [AW-1:0]         ram_raddr_b;
    t_entry                ram_rdata_a;
    t_entry                ram_rdata_b;
    t_entry                fwd_a;
    t_entry                fwd_b;
    t_coin                 cval;
    logic                  coin_ok;
    logic                  last_coin;

    ccwc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_AMOUNT)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Coin lookup; slots without a register read as zero and are skipped.
    always_comb begin
        cval = '0;
        if (r_coin < COIN_IDX_W'(CFG_REGS)) begin
            cval = r_coin_reg[r_coin[CFG_IDX_W-1:0]];
        end
    end

    assign last_coin = (r_coin >= COIN_IDX_W'(NUM_COINS));
    assign coin_ok   = (cval != '0) && (CMP_W'(cval) <= CMP_W'(r_amount));

    assign ram_raddr_a = (r_state == S_PASS) ? r_addr : r_amount;
    assign ram_raddr_b = r_addr - r_c;

    // Read-first RAM: the write of the cycle before the read data is forwarded.
    assign fwd_a = (r_fw_vld && r_fw_addr == r_p1_addr)  ? r_fw_data : ram_rdata_a;
    assign fwd_b = (r_fw_vld && r_fw_addr == r_p1_baddr) ? r_fw_data : ram_rdata_b;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = ENTRY_W'(r_addr == '0);
        if (r_state == S_CLEAR) begin
            ram_we = 1'b1;
        end else if (r_p1) begin
            ram_we    = 1'b1;
            ram_waddr = r_p1_addr;
            ram_wdata = sat_add(fwd_a, fwd_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_p1        <= 1'b0;
            r_fw_vld    <= 1'b0;
            o_out_valid <= 1'b0;
            for (int i = 0; i < CFG_REGS; i++) begin
                r_coin_reg[i] <= COIN_RESET[i];
            end
        end else begin
            r_p1       <= (r_state == S_PASS);
            r_p1_addr  <= ram_raddr_a;
            r_p1_baddr <= ram_raddr_b;
            if (ram_we) begin
                r_fw_vld  <= 1'b1;
                r_fw_addr <= ram_waddr;
                r_fw_data <= ram_wdata;
            end

            for (int i = 0; i < CFG_REGS; i++) begin
                if (i_cfg_valid && i_cfg_index == CFG_IDX_W'(i)) begin
                    r_coin_reg[i] <= i_cfg_data;
                end
            end

            if (o_out_valid && !i_out_stall && r_state != S_DONE) begin
                o_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_coin <= COIN_IDX_W'(i_first_coin);
                        r_addr <= '0;
                        if (CMP_W'(i_amount) >= CMP_W'(MAX_AMOUNT)) begin
                            r_res   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_amount <= AW'(i_amount);
                            r_state  <= S_CLEAR;
                        end
                    end
                end
                S_CLEAR: begin
                    if (r_addr == r_amount) begin
                        r_state <= S_SEL;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                S_SEL: begin
                    if (last_coin) begin
                        r_state <= S_RD;
                    end else begin
                        r_coin <= r_coin + COIN_IDX_W'(1);
                        if (coin_ok) begin
                            r_c     <= AW'(cval);
                            r_addr  <= AW'(cval);
                            r_state <= S_PASS;
                        end
                    end
                end
                S_PASS: begin
                    if (r_addr == r_amount) begin
                        r_state <= S_SEL;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                S_RD: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    r_res   <= fwd_a;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!o_out_valid || !i_out_stall) begin
                        o_ways      <= r_res[COUNT_W-1:0];
                        o_overflow  <= r_res[ENTRY_W-1];
                        o_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (ram_waddr <= r_amount))
        else $error("table write beyond the query amount");

    a_pass_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PASS) |-> (r_c != '0 && r_c <= r_addr))
        else $error("update reads below table entry zero");

    a_pipe_follows_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PASS) |=> r_p1)
        else $error("update stage lost a pass read");

    a_pipe_only_after_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_PASS) |=> !r_p1)
        else $error("update stage wrote without a pass read");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_CLEAR || r_state == S_DONE))
        else $error("accepted query did not start");

endmodule
